[sv/sbpe_pkg.sv]
// Package of the scan-line bright point extractor.
// Holds the beat types, register indexes, reset values and the coordinate clamp.
// Depends on nothing; the top level and sbpe_judge import it.
package sbpe_pkg;

	localparam int unsigned COORD_LIMIT = 4096;
	localparam int unsigned POS_W = 12;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 12;

	localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 8'd180;
	localparam logic [POS_W-1:0] SAME_RESET = 12'd3;
	localparam logic [POS_W-1:0] CLOSE_RESET = 12'd10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BRIGHT_LEVEL = 2'd0,
		REG_SAME_GAP = 2'd1,
		REG_CLOSE_GAP = 2'd2
	} reg_index_t;

	typedef enum logic {
		ACT_APPEND = 1'b0,
		ACT_REPLACE = 1'b1
	} action_t;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic line_start;
		logic is_row_scan;
		pos_t across_pos;
		pos_t along_pos;
		logic [LEVEL_W-1:0] blue;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] bright_level;
		pos_t same_gap;
		pos_t close_gap;
	} cfg_t;

	typedef struct packed {
		pos_t last_spot;
		logic spot_seen;
	} spot_state_t;

	typedef struct packed {
		action_t action;
		pos_t point_y;
		pos_t point_x;
	} point_t;

	typedef struct packed {
		logic has_point;
		point_t point;
		spot_state_t next_state;
	} judge_t;

	function automatic pos_t clamp_pos(input pos_t p);
		pos_t r;
		r = p;
		if (32'(p) >= COORD_LIMIT) begin
			r = POS_W'(COORD_LIMIT - 1);
		end
		return r;
	endfunction

endpackage

[sv/scanline_bright_point_extractor.sv]
// Top level of the scan-line bright point extractor: input register, spot state,
// configuration registers and result register. Depends on sbpe_pkg and sbpe_judge.
// Path: an accepted pixel waits in the input register, is judged, and its point goes to the result register.
// Throughput: one pixel per cycle; only a stalled result register holds the input.
// Reset: arst_n clears the beat valids and the spot state at once and loads the
// register reset values; there is no clearing pass.
module scanline_bright_point_extractor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// red[7:0], green[15:8], blue[23:16], along_pos[35:24], across_pos[47:36]
	input  logic [47:0]                       s_axis_tdata,
	// is_row_scan[0], line_start[1]
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// point_x[11:0], point_y[23:12]
	output logic [23:0]                       m_axis_tdata,
	// action[0]
	output logic [0:0]                        m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbpe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sbpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sbpe_pkg::*;

	pixel_t pixel_s1;
	logic valid_s1;
	point_t point_s2;
	logic valid_s2;
	cfg_t cfg_q;
	spot_state_t state_q;
	judge_t judge;
	logic out_free;
	logic advance;

	assign out_free = !valid_s2 || m_axis_tready;
	assign advance = valid_s1 && (out_free || !judge.has_point);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	sbpe_judge u_judge (
		.pixel(pixel_s1),
		.cfg(cfg_q),
		.state(state_q),
		.judge(judge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pixel_s1 <= {s_axis_tuser[1], s_axis_tuser[0], s_axis_tdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && judge.has_point;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && judge.has_point) begin
			point_s2 <= judge.point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= judge.next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_level <= BRIGHT_RESET;
			cfg_q.same_gap <= SAME_RESET;
			cfg_q.close_gap <= CLOSE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BRIGHT_LEVEL: cfg_q.bright_level <= cfg_data[LEVEL_W-1:0];
				REG_SAME_GAP: cfg_q.same_gap <= cfg_data[POS_W-1:0];
				REG_CLOSE_GAP: cfg_q.close_gap <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {point_s2.point_y, point_s2.point_x};
	assign m_axis_tuser = point_s2.action;

endmodule

[sv/sbpe_judge.sv]
// Per-pixel decision of the bright point extractor: brightness test, distance
// to the remembered spot, and the append, replace or track choice.
// Depends on sbpe_pkg.
module sbpe_judge (
	input  sbpe_pkg::pixel_t      pixel,
	input  sbpe_pkg::cfg_t        cfg,
	input  sbpe_pkg::spot_state_t state,
	output sbpe_pkg::judge_t      judge
);
	import sbpe_pkg::*;

	pos_t along;
	pos_t across;
	pos_t spot_dist;
	pos_t mid;
	pos_t along_out;
	logic seen;
	logic bright;

	always_comb begin
		along = clamp_pos(pixel.along_pos);
		across = clamp_pos(pixel.across_pos);
		seen = state.spot_seen & ~pixel.line_start;
		bright = (pixel.red > cfg.bright_level) && (pixel.green > cfg.bright_level)
			&& (pixel.blue > cfg.bright_level);
		spot_dist = (along >= state.last_spot) ? along - state.last_spot
			: state.last_spot - along;
		mid = POS_W'(({1'b0, state.last_spot} + {1'b0, along}) >> 1);

		judge.has_point = 1'b0;
		judge.point.action = ACT_APPEND;
		judge.next_state.spot_seen = seen;
		judge.next_state.last_spot = state.last_spot;
		along_out = along;

		priority if (!bright) begin
			judge.has_point = 1'b0;
		end else if (!seen) begin
			judge.has_point = 1'b1;
			judge.next_state.spot_seen = 1'b1;
			judge.next_state.last_spot = along;
		end else if (spot_dist < cfg.same_gap) begin
			judge.next_state.last_spot = along;
		end else if (spot_dist > cfg.close_gap) begin
			judge.has_point = 1'b1;
			judge.next_state.last_spot = along;
		end else begin
			judge.has_point = 1'b1;
			judge.point.action = ACT_REPLACE;
			judge.next_state.last_spot = mid;
			along_out = mid;
		end

		judge.point.point_x = pixel.is_row_scan ? along_out : across;
		judge.point.point_y = pixel.is_row_scan ? across : along_out;
	end

endmodule

[sv/sbpe_checker.sv]
// Port-level checks of the scan-line bright point extractor, bound to the top level.
// Depends only on the top level's ports.
module sbpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("Result beat changed while stalled.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("Input stalled although the result register is empty.");

	a_result_follows_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("Result beat appeared without a pixel accepted two cycles before.");

endmodule

bind scanline_bright_point_extractor sbpe_checker u_sbpe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
